@@ rtl/hbr_pkg.sv @@
// ----------------------------------------------------------------------------
// hbr_pkg
// Types and codes shared by the block Hadamard rotation unit.
// ----------------------------------------------------------------------------
package hbr_pkg;

	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_SIGN   = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic [2:0] REG_BLOCK_LOG2   = 3'd0;
	localparam logic [2:0] REG_ROW_BLOCKS   = 3'd1;
	localparam logic [2:0] REG_SIGNS_ENABLE = 3'd2;
	localparam logic [2:0] REG_PERM_ENABLE  = 3'd3;
	localparam logic [2:0] REG_PERM_REP     = 3'd4;
	localparam logic [2:0] REG_PERM_GROUPS  = 3'd5;
	localparam logic [2:0] REG_PERM_HEAD    = 3'd6;

	localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;
	localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

	typedef struct packed {
		logic [1:0]         mode;
		logic [12:0]        table_index;
		logic signed [15:0] sample_value;
		logic signed [15:0] sign_factor;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] output_value;
		logic               saturated;
		logic               row_last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [12:0]        idx;
		logic signed [15:0] data;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  block_log2;
		logic [5:0]  row_blocks;
		logic        signs_enable;
		logic        perm_enable;
		logic [13:0] perm_rep;
		logic [13:0] perm_groups;
		logic [13:0] perm_head;
	} cfg_t;

	typedef struct packed {
		logic pop;
		logic rotating;
		logic row_ready;
	} eng_status_t;

endpackage

@@ rtl/hbr_ram.sv @@
// ----------------------------------------------------------------------------
// hbr_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hbr_ram #(
	parameter int W = 16,
	parameter int D = 8192
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr_a,
	input  logic [$clog2(D)-1:0] raddr_b,
	output logic [W-1:0]         rdata_a,
	output logic [W-1:0]         rdata_b
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

@@ rtl/hbr_front.sv @@
// ----------------------------------------------------------------------------
// hbr_front
// Accepts items, drops meaningless ones and queues commands for the engine.
// ----------------------------------------------------------------------------
module hbr_front import hbr_pkg::*; #(
	parameter int ROW_MAX = 8192
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     q_valid,
	output cmd_t     q_cmd,
	input  logic     q_pop
);
	localparam int QD = 4;

	cmd_t         queue_q [QD];
	logic [1:0]   wr_ptr_q, rd_ptr_q;
	logic [2:0]   cnt_q;
	logic         keep, push;
	logic [31:0]  idx32;

	assign idx32    = 32'(in_item.table_index);
	assign keep     = (in_item.mode != MODE_NONE) &&
	                  !(in_item.mode == MODE_SIGN && idx32 >= 32'(ROW_MAX));
	assign in_ready = (cnt_q != 3'(QD));
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != 3'd0);
	assign q_cmd    = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q].kind <= in_item.mode;
			queue_q[wr_ptr_q].idx  <= in_item.table_index;
			queue_q[wr_ptr_q].data <= (in_item.mode == MODE_SIGN) ?
			                          in_item.sign_factor : in_item.sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end
endmodule

@@ rtl/hbr_engine.sv @@
// ----------------------------------------------------------------------------
// hbr_engine
// Executes queued commands: row and sign table loads, permuted sign multiply, butterflies,
// scaling with rounding and saturation, and result drain.
// ----------------------------------------------------------------------------
module hbr_engine import hbr_pkg::*; #(
	parameter int ROW_MAX        = 8192,
	parameter int BLOCK_LOG2_MAX = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        out_valid,
	output out_item_t   out_item,
	input  logic        out_ready,
	output eng_status_t status
);
	localparam int AW       = $clog2(ROW_MAX);
	localparam int LW       = $clog2(ROW_MAX + 1);
	localparam int LOG2_ROW = $clog2(ROW_MAX + 1) - 1;
	localparam int LMAX0    = (BLOCK_LOG2_MAX < LOG2_ROW) ? BLOCK_LOG2_MAX : LOG2_ROW;
	localparam int LMAX     = (LMAX0 < 8) ? 8 : LMAX0;
	localparam int WW       = 32 + BLOCK_LOG2_MAX;
	localparam int SPLIT    = WW / 2;
	localparam int PW       = WW + 17;
	localparam int SW       = 48;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_RDW   = 5'd1;
	localparam logic [4:0] ST_PSET  = 5'd2;
	localparam logic [4:0] ST_PRD   = 5'd3;
	localparam logic [4:0] ST_PMUL  = 5'd4;
	localparam logic [4:0] ST_PWR   = 5'd5;
	localparam logic [4:0] ST_BRD   = 5'd6;
	localparam logic [4:0] ST_BW1   = 5'd7;
	localparam logic [4:0] ST_BW2   = 5'd8;
	localparam logic [4:0] ST_SRD   = 5'd9;
	localparam logic [4:0] ST_SMUL  = 5'd10;
	localparam logic [4:0] ST_SSUM  = 5'd11;
	localparam logic [4:0] ST_SABS  = 5'd12;
	localparam logic [4:0] ST_SRND  = 5'd13;
	localparam logic [4:0] ST_SWR   = 5'd14;

	logic [4:0]    state_q;
	logic          row_ready_q;
	logic [LW-1:0] load_cnt_q, read_cnt_q, len_q, p_q;
	logic [3:0]    l_q, st_q;
	logic [5:0]    sh_q;
	logic [AW-1:0] pr_q;
	logic          out_valid_q;
	out_item_t     out_q;

	// effective geometry
	logic [3:0]    l_eff;
	logic [LW-1:0] maxb, nb, len_eff;
	always_comb begin
		l_eff = cfg.block_log2;
		if (l_eff < 4'd8) begin
			l_eff = 4'd8;
		end
		if (l_eff > 4'(LMAX)) begin
			l_eff = 4'(LMAX);
		end
		maxb = LW'(ROW_MAX) >> l_eff;
		nb   = (cfg.row_blocks == 6'd0) ? LW'(1) : LW'(cfg.row_blocks);
		if (nb > maxb) begin
			nb = maxb;
		end
		len_eff = nb << l_eff;
	end

	// permutation walk
	logic [13:0]   rep_e, grp_e, hd_e, h_q, r_q;
	logic [27:0]   gh_q;
	logic [SW-1:0] kacc_q, acc_q, src;
	logic [LW-1:0] src_sel;
	assign rep_e   = (cfg.perm_rep == 14'd0) ? 14'd1 : cfg.perm_rep;
	assign grp_e   = (cfg.perm_groups == 14'd0) ? 14'd1 : cfg.perm_groups;
	assign hd_e    = (cfg.perm_head == 14'd0) ? 14'd1 : cfg.perm_head;
	assign src     = acc_q + SW'(h_q);
	assign src_sel = (!cfg.perm_enable || src >= SW'(len_q)) ? p_q : src[LW-1:0];

	// butterfly addresses
	logic [AW-1:0] bit_st, mask, lo_addr, hi_addr;
	logic [LW-1:0] half;
	assign bit_st  = AW'(1) << st_q;
	assign mask    = bit_st - AW'(1);
	assign lo_addr = ((pr_q & ~mask) << 1) | (pr_q & mask);
	assign hi_addr = lo_addr | bit_st;
	assign half    = len_q >> 1;

	// memories
	logic          smp_we, sgn_we, wrk_we;
	logic [AW-1:0] smp_waddr, sgn_waddr, wrk_waddr, smp_raddr, sgn_raddr;
	logic [AW-1:0] wrk_raddr_a, wrk_raddr_b;
	logic [15:0]   smp_rdata, sgn_rdata;
	logic [WW-1:0] wrk_wdata, wrk_rdata_a, wrk_rdata_b;

	hbr_ram #(.W(16), .D(ROW_MAX)) u_smp (
		.clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(q_cmd.data),
		.raddr_a(smp_raddr), .raddr_b(smp_raddr), .rdata_a(smp_rdata), .rdata_b()
	);
	hbr_ram #(.W(16), .D(ROW_MAX)) u_sgn (
		.clk(clk), .we(sgn_we), .waddr(sgn_waddr), .wdata(q_cmd.data),
		.raddr_a(sgn_raddr), .raddr_b(sgn_raddr), .rdata_a(sgn_rdata), .rdata_b()
	);
	hbr_ram #(.W(WW), .D(ROW_MAX)) u_wrk (
		.clk(clk), .we(wrk_we), .waddr(wrk_waddr), .wdata(wrk_wdata),
		.raddr_a(wrk_raddr_a), .raddr_b(wrk_raddr_b),
		.rdata_a(wrk_rdata_a), .rdata_b(wrk_rdata_b)
	);

	// datapath registers
	logic signed [31:0]         prod_q;
	logic signed [WW-1:0]       diff_q;
	logic [SPLIT+16:0]          mlo_q;
	logic signed [WW-SPLIT+17:0] mhi_q;
	logic signed [PW-1:0]       sc_q, ext_hi, ext_lo;
	logic                       neg_q;
	logic [PW-1:0]              mag_q, qv_q;
	logic [16:0]                mult;
	logic signed [WW-1:0]       a_s, d_s;

	assign mult   = l_q[0] ? INV_SQRT2_Q16 : 17'd1;
	assign ext_hi = PW'(mhi_q);
	assign ext_lo = PW'(mlo_q);
	assign a_s    = wrk_rdata_a;
	assign d_s    = wrk_rdata_b;

	// result formatting
	logic        sat;
	logic [15:0] qv16, val16;
	always_comb begin
		sat  = 1'b0;
		qv16 = qv_q[15:0];
		if (!neg_q && qv_q > PW'(32767)) begin
			sat  = 1'b1;
			qv16 = 16'd32767;
		end else if (neg_q && qv_q > PW'(32768)) begin
			sat  = 1'b1;
			qv16 = 16'd32768;
		end
		val16 = neg_q ? (16'd0 - qv16) : qv16;
	end

	logic can_go;
	logic [LW:0] load_next, read_next;
	assign can_go    = !(q_cmd.kind == MODE_READ && row_ready_q && out_valid_q);
	assign q_pop     = (state_q == ST_IDLE) && q_valid && can_go;
	assign load_next = {1'b0, load_cnt_q} + (LW+1)'(1);
	assign read_next = {1'b0, read_cnt_q} + (LW+1)'(1);

	always_comb begin
		smp_we      = q_pop && q_cmd.kind == MODE_SAMPLE && !row_ready_q;
		smp_waddr   = load_cnt_q[AW-1:0];
		sgn_we      = q_pop && q_cmd.kind == MODE_SIGN;
		sgn_waddr   = AW'(q_cmd.idx);
		smp_raddr   = src_sel[AW-1:0];
		sgn_raddr   = p_q[AW-1:0];
		wrk_we      = 1'b0;
		wrk_waddr   = p_q[AW-1:0];
		wrk_wdata   = WW'(prod_q);
		wrk_raddr_a = read_cnt_q[AW-1:0];
		wrk_raddr_b = hi_addr;
		unique case (state_q)
			ST_PWR: begin
				wrk_we = 1'b1;
			end
			ST_BRD: begin
				wrk_raddr_a = lo_addr;
			end
			ST_BW1: begin
				wrk_we    = 1'b1;
				wrk_waddr = lo_addr;
				wrk_wdata = a_s + d_s;
			end
			ST_BW2: begin
				wrk_we    = 1'b1;
				wrk_waddr = hi_addr;
				wrk_wdata = diff_q;
			end
			ST_SRD: begin
				wrk_raddr_a = p_q[AW-1:0];
			end
			ST_SWR: begin
				wrk_we    = 1'b1;
				wrk_wdata = WW'({sat, val16});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_ready_q <= 1'b0;
			load_cnt_q  <= '0;
			read_cnt_q  <= '0;
			len_q       <= '0;
			l_q         <= 4'd8;
			sh_q        <= '0;
			p_q         <= '0;
			st_q        <= '0;
			pr_q        <= '0;
			h_q         <= '0;
			r_q         <= '0;
			kacc_q      <= '0;
			acc_q       <= '0;
			gh_q        <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			prod_q      <= '0;
			diff_q      <= '0;
			mlo_q       <= '0;
			mhi_q       <= '0;
			sc_q        <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			qv_q        <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.kind)
							MODE_SAMPLE: begin
								if (!row_ready_q) begin
									if (load_next >= {1'b0, len_eff}) begin
										load_cnt_q <= '0;
										len_q      <= len_eff;
										l_q        <= l_eff;
										sh_q       <= 6'd14 + 6'(l_eff >> 1) +
										              (l_eff[0] ? 6'd16 : 6'd0);
										state_q    <= ST_PSET;
									end else begin
										load_cnt_q <= load_next[LW-1:0];
									end
								end
							end
							MODE_READ: begin
								if (row_ready_q) begin
									state_q <= ST_RDW;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RDW: begin
					out_valid_q           <= 1'b1;
					out_q.output_value    <= wrk_rdata_a[15:0];
					out_q.saturated       <= wrk_rdata_a[16];
					out_q.row_last        <= (read_next >= {1'b0, len_q});
					if (read_next >= {1'b0, len_q}) begin
						row_ready_q <= 1'b0;
						read_cnt_q  <= '0;
					end else begin
						read_cnt_q <= read_next[LW-1:0];
					end
					state_q <= ST_IDLE;
				end
				ST_PSET: begin
					gh_q    <= grp_e * hd_e;
					p_q     <= '0;
					h_q     <= '0;
					r_q     <= '0;
					kacc_q  <= '0;
					acc_q   <= '0;
					state_q <= ST_PRD;
				end
				ST_PRD: begin
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					prod_q  <= $signed(smp_rdata) *
					           (cfg.signs_enable ? $signed(sgn_rdata) : UNIT_Q14);
					state_q <= ST_PWR;
				end
				ST_PWR: begin
					if (15'(h_q) + 15'd1 == 15'(hd_e)) begin
						h_q <= '0;
						if (15'(r_q) + 15'd1 == 15'(rep_e)) begin
							r_q    <= '0;
							kacc_q <= kacc_q + SW'(hd_e);
							acc_q  <= kacc_q + SW'(hd_e);
						end else begin
							r_q   <= r_q + 14'd1;
							acc_q <= acc_q + SW'(gh_q);
						end
					end else begin
						h_q <= h_q + 14'd1;
					end
					if (p_q + LW'(1) == len_q) begin
						st_q    <= '0;
						pr_q    <= '0;
						state_q <= ST_BRD;
					end else begin
						p_q     <= p_q + LW'(1);
						state_q <= ST_PRD;
					end
				end
				ST_BRD: begin
					state_q <= ST_BW1;
				end
				ST_BW1: begin
					diff_q  <= a_s - d_s;
					state_q <= ST_BW2;
				end
				ST_BW2: begin
					if (LW'(pr_q) + LW'(1) == half) begin
						pr_q <= '0;
						if (st_q + 4'd1 == l_q) begin
							p_q     <= '0;
							state_q <= ST_SRD;
						end else begin
							st_q    <= st_q + 4'd1;
							state_q <= ST_BRD;
						end
					end else begin
						pr_q    <= pr_q + AW'(1);
						state_q <= ST_BRD;
					end
				end
				ST_SRD: begin
					state_q <= ST_SMUL;
				end
				ST_SMUL: begin
					mlo_q   <= wrk_rdata_a[SPLIT-1:0] * mult;
					mhi_q   <= $signed(wrk_rdata_a[WW-1:SPLIT]) * $signed({1'b0, mult});
					state_q <= ST_SSUM;
				end
				ST_SSUM: begin
					sc_q    <= (ext_hi <<< SPLIT) + ext_lo;
					state_q <= ST_SABS;
				end
				ST_SABS: begin
					neg_q   <= sc_q[PW-1];
					mag_q   <= sc_q[PW-1] ? (PW'(0) - PW'(sc_q)) : PW'(sc_q);
					state_q <= ST_SRND;
				end
				ST_SRND: begin
					qv_q    <= (mag_q + (PW'(1) << (sh_q - 6'd1))) >> sh_q;
					state_q <= ST_SWR;
				end
				ST_SWR: begin
					if (p_q + LW'(1) == len_q) begin
						row_ready_q <= 1'b1;
						read_cnt_q  <= '0;
						state_q     <= ST_IDLE;
					end else begin
						p_q     <= p_q + LW'(1);
						state_q <= ST_SRD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign out_item         = out_q;
	assign status.pop       = q_pop;
	assign status.rotating  = (state_q != ST_IDLE) && (state_q != ST_RDW);
	assign status.row_ready = row_ready_q;
endmodule

@@ rtl/signed_block_hadamard_rotation_unit.sv @@
// ----------------------------------------------------------------------------
// signed_block_hadamard_rotation_unit
// Blockwise signed Walsh-Hadamard rotation of one activation row.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | in_item   (mode, index, sample, factor)
//  out     | out_valid/out_ready | out_item  (value, saturated, row_last)
//  cfg     | cfg_we              | cfg_index, cfg_data
//
//  Sample and sign loads are written to their RAMs as they are popped; a read
//  waits in a read state for the registered RAM output. The completing sample
//  starts the rotation: permuted sign multiply, butterflies (one work RAM write
//  port), then scaling. No clearing pass after reset.
//  A four-entry command queue lets input keep flowing while the engine stalls.
// ----------------------------------------------------------------------------
module signed_block_hadamard_rotation_unit import hbr_pkg::*; #(
	parameter int ROW_MAX        = 8192,
	parameter int BLOCK_LOG2_MAX = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);
	cfg_t        cfg_q;
	logic        q_valid, q_pop;
	cmd_t        q_cmd;
	eng_status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_log2   <= 4'd8;
			cfg_q.row_blocks   <= 6'd1;
			cfg_q.signs_enable <= 1'b0;
			cfg_q.perm_enable  <= 1'b0;
			cfg_q.perm_rep     <= 14'd1;
			cfg_q.perm_groups  <= 14'd1;
			cfg_q.perm_head    <= 14'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_LOG2:   cfg_q.block_log2   <= cfg_data[3:0];
				REG_ROW_BLOCKS:   cfg_q.row_blocks   <= cfg_data[5:0];
				REG_SIGNS_ENABLE: cfg_q.signs_enable <= cfg_data[0];
				REG_PERM_ENABLE:  cfg_q.perm_enable  <= cfg_data[0];
				REG_PERM_REP:     cfg_q.perm_rep     <= cfg_data;
				REG_PERM_GROUPS:  cfg_q.perm_groups  <= cfg_data;
				REG_PERM_HEAD:    cfg_q.perm_head    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hbr_front #(.ROW_MAX(ROW_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	hbr_engine #(.ROW_MAX(ROW_MAX), .BLOCK_LOG2_MAX(BLOCK_LOG2_MAX)) u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_cmd(q_cmd),
		.q_pop(q_pop), .out_valid(out_valid), .out_item(out_item),
		.out_ready(out_ready), .status(st)
	);

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		st.pop |-> q_valid) else $error("pop from empty queue");

	a_ready_after_rotation: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st.row_ready) |-> $past(st.rotating)) else $error("row ready without rotation");

	a_no_ready_while_rotating: assert property (@(posedge clk) disable iff (!arst_n)
		st.rotating |-> !st.row_ready) else $error("rotation over a pending row");
endmodule

@@ tb/signed_block_hadamard_rotation_unit_tb.sv @@
// ----------------------------------------------------------------------------
// signed_block_hadamard_rotation_unit_tb
// Self-checking bench for the block Hadamard rotation unit. A behavioural
// predictor keeps its own row store, sign table and counters, works out each
// rotated row when its last sample is accepted and queues one expected item
// per successful read. Results are compared field by field as they leave the
// block. Directed rows cover the extremes and corner cases; random rows follow
// with random input idling and output backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module signed_block_hadamard_rotation_unit_tb;
	import hbr_pkg::*;

	localparam int ROW_MAX     = 8192;
	localparam int SIGN_FILL   = 256;
	localparam int CYCLE_LIMIT = 4000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [13:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;

	signed_block_hadamard_rotation_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// predictor state
	logic [3:0]  m_block_log2;
	logic [5:0]  m_row_blocks;
	logic        m_signs_en;
	logic        m_perm_en;
	logic [13:0] m_rep, m_groups, m_head;
	logic [16:0] m_rows [ROW_MAX];
	logic [15:0] m_signs [ROW_MAX];
	longint      m_acc [ROW_MAX];
	int          m_loaded, m_read, m_row_len;
	logic        m_pending;

	out_item_t   expected_q [$];
	int          errors;
	int          cycles;
	int          hold_req;
	logic        no_idle;
	int          sent_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL signed_block_hadamard_rotation_unit");
			$finish;
		end
	end

	function automatic int block_bits();
		int l;
		l = int'(m_block_log2);
		if (l < 8) l = 8;
		if (l > 12) l = 12;
		while (l > 8 && (1 << l) > ROW_MAX) l--;
		return l;
	endfunction

	function automatic int row_length(int l);
		int nb, maxb;
		nb = (m_row_blocks != 6'd0) ? int'(m_row_blocks) : 1;
		maxb = ROW_MAX >> l;
		if (maxb == 0) maxb = 1;
		if (nb > maxb) nb = maxb;
		return nb << l;
	endfunction

	function automatic int source_pos(int p, int len);
		longint unsigned rep, grp, hd, span, k, rem, r, h, src;
		if (!m_perm_en) return p;
		rep = (m_rep != 14'd0) ? 64'(m_rep) : 64'd1;
		grp = (m_groups != 14'd0) ? 64'(m_groups) : 64'd1;
		hd = (m_head != 14'd0) ? 64'(m_head) : 64'd1;
		span = rep * hd;
		k = 64'(p) / span;
		rem = 64'(p) - k * span;
		r = rem / hd;
		h = rem - r * hd;
		src = (r * grp + k) * hd + h;
		return (src < 64'(len)) ? int'(src) : p;
	endfunction

	task automatic rotate_and_scale();
		int l, len, blk, sh, p, b, i, j, k;
		longint x, s, a, d, t;
		longint unsigned mag, q;
		logic neg, sat;
		logic [15:0] v;
		l = block_bits();
		len = row_length(l);
		blk = 1 << l;
		for (p = 0; p < len; p++) begin
			x = longint'($signed(m_rows[source_pos(p, len)][15:0]));
			s = m_signs_en ? longint'($signed(m_signs[p])) : 64'sd16384;
			m_acc[p] = x * s;
		end
		for (b = 0; b < len; b += blk)
			for (i = 1; i < blk; i *= 2)
				for (j = 0; j < blk; j += 2 * i)
					for (k = 0; k < i; k++) begin
						a = m_acc[b + j + k];
						d = m_acc[b + j + k + i];
						m_acc[b + j + k] = a + d;
						m_acc[b + j + k + i] = a - d;
					end
		sh = 14 + l / 2 + ((l % 2 == 1) ? 16 : 0);
		for (p = 0; p < len; p++) begin
			t = m_acc[p];
			if (l % 2 == 1) t = t * 46341;
			neg = t < 0;
			mag = neg ? longint'(0) - t : t;
			q = (mag + (64'd1 << (sh - 1))) >> sh;
			sat = 1'b0;
			if (!neg && q > 32767) begin
				q = 32767;
				sat = 1'b1;
			end
			if (neg && q > 32768) begin
				q = 32768;
				sat = 1'b1;
			end
			v = neg ? 16'(17'h10000 - q) : 16'(q);
			m_rows[p] = {sat, v};
		end
		m_row_len = len;
	endtask

	task automatic predict_item(in_item_t it);
		logic [16:0] e;
		out_item_t   x;
		case (it.mode)
			MODE_SAMPLE: begin
				if (!m_pending) begin
					if (m_loaded < ROW_MAX) m_rows[m_loaded] = {1'b0, it.sample_value};
					m_loaded++;
					if (m_loaded >= row_length(block_bits())) begin
						rotate_and_scale();
						m_loaded = 0;
						m_read = 0;
						m_pending = 1'b1;
					end
				end
			end
			MODE_SIGN: begin
				m_signs[it.table_index] = it.sign_factor;
			end
			MODE_READ: begin
				if (m_pending && m_read < ROW_MAX) begin
					e = m_rows[m_read];
					m_read++;
					x.output_value = e[15:0];
					x.saturated = e[16];
					x.row_last = (m_read >= m_row_len);
					expected_q.insert(expected_q.size(), x);
					if (m_read >= m_row_len) begin
						m_pending = 1'b0;
						m_read = 0;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic int idle_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic send_item(logic [1:0] mode, logic [12:0] idx, logic [15:0] smp,
			logic [15:0] fac);
		int g;
		in_item = '{mode, idx, smp, fac};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_item(in_item);
		sent_count++;
		@(negedge clk);
		in_valid = 1'b0;
		g = idle_len();
		repeat (g) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[13:0];
		case (idx)
			REG_BLOCK_LOG2:   m_block_log2 = value[3:0];
			REG_ROW_BLOCKS:   m_row_blocks = value[5:0];
			REG_SIGNS_ENABLE: m_signs_en = value[0];
			REG_PERM_ENABLE:  m_perm_en = value[0];
			REG_PERM_REP:     m_rep = value[13:0];
			REG_PERM_GROUPS:  m_groups = value[13:0];
			REG_PERM_HEAD:    m_head = value[13:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain_results();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_config(int bl, int rb, int se, int pe, int rep, int grp, int hd);
		drain_results();
		write_reg(REG_BLOCK_LOG2, bl);
		write_reg(REG_ROW_BLOCKS, rb);
		write_reg(REG_SIGNS_ENABLE, se);
		write_reg(REG_PERM_ENABLE, pe);
		write_reg(REG_PERM_REP, rep);
		write_reg(REG_PERM_GROUPS, grp);
		write_reg(REG_PERM_HEAD, hd);
	endtask

	// pattern: 0 random with four extreme leading values, 1 all max, 2 all min, 3 small values
	task automatic load_row(int pattern);
		int len, p;
		logic [15:0] v;
		len = row_length(block_bits());
		for (p = 0; p < len; p++) begin
			case (pattern)
				1: v = 16'h7fff;
				2: v = 16'h8000;
				3: v = 16'($signed($urandom_range(0, 511)) - 256);
				default: v = 16'($urandom());
			endcase
			if (p < 4 && pattern == 0) v = (p == 0) ? 16'h8000 : (p == 1) ? 16'h7fff :
				(p == 2) ? 16'h0000 : 16'hffff;
			send_item(MODE_SAMPLE, 13'($urandom()), v, 16'($urandom()));
		end
	endtask

	task automatic read_row(int extra);
		int len, p;
		len = m_row_len;
		for (p = 0; p < len + extra; p++)
			send_item(MODE_READ, 13'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	task automatic test_empty_reads();
		send_item(MODE_READ, 13'h1fff, 16'hffff, 16'hffff);
		send_item(MODE_NONE, 13'h0, 16'h0, 16'h0);
		send_item(MODE_NONE, 13'h1fff, 16'hffff, 16'hffff);
		send_item(MODE_READ, 13'h0, 16'h0, 16'h0);
	endtask

	task automatic test_sign_fill();
		int p;
		logic [15:0] f;
		for (p = 0; p < SIGN_FILL; p++) begin
			f = (p == 0) ? 16'h8000 : (p == 1) ? 16'h7fff : (p == 2) ? 16'h0000 :
				(p == 3) ? 16'hffff : (p == 4) ? 16'h4000 : 16'($urandom());
			send_item(MODE_SIGN, p[12:0], 16'($urandom()), f);
		end
	endtask

	task automatic test_basic_rows();
		set_config(9, 1, 0, 1, 2, 4, 64);
		load_row(0);
		read_row(1);
	endtask

	task automatic test_saturation();
		set_config(8, 1, 1, 0, 1, 1, 1);
		load_row(1);
		send_item(MODE_SAMPLE, 13'd0, 16'h1234, 16'd0);
		read_row(2);
	endtask

	task automatic test_range_limits();
		set_config(7, 0, 1, 1, 7, 40, 0);
		load_row(3);
		read_row(1);
	endtask

	task automatic test_resize_mid_row();
		int p;
		set_config(8, 2, 1, 0, 1, 1, 1);
		for (p = 0; p < 256; p++) send_item(MODE_SAMPLE, 13'd0, 16'($urandom()), 16'd0);
		repeat (30) @(negedge clk);
		write_reg(REG_ROW_BLOCKS, 1);
		send_item(MODE_SAMPLE, 13'd0, 16'($urandom()), 16'd0);
		read_row(0);
	endtask

	task automatic test_backpressure();
		set_config(8, 1, 1, 1, 4, 4, 16);
		no_idle = 1'b1;
		load_row(0);
		hold_req = 2000;
		read_row(0);
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		int start, bl, len, rep, grp, hd, p, r, se;
		start = sent_count;
		while (sent_count - start < 500) begin
			bl = ($urandom_range(0, 3) == 0) ? 9 : 8;
			if ($urandom_range(0, 1)) begin
				hd = 1 << $urandom_range(0, bl);
				rep = 1 << $urandom_range(0, bl - $clog2(hd));
				grp = (1 << bl) / (hd * rep);
			end else begin
				hd = $urandom_range(0, 16383);
				rep = $urandom_range(0, 16383);
				grp = $urandom_range(0, 40);
			end
			se = (bl == 8) ? int'($urandom_range(0, 1)) : 0;
			set_config(bl, 1, se, $urandom_range(0, 1), rep, grp, hd);
			no_idle = ($urandom_range(0, 3) == 0);
			len = row_length(block_bits());
			for (p = 0; p < len; p++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					send_item(MODE_READ, 13'($urandom()), 16'($urandom()), 16'($urandom()));
				else if (r < 5)
					send_item(MODE_NONE, 13'($urandom()), 16'($urandom()), 16'($urandom()));
				else if (r < 8)
					send_item(MODE_SIGN, 13'($urandom()), 16'($urandom()), 16'($urandom()));
				send_item(MODE_SAMPLE, 13'($urandom()), 16'($urandom()), 16'($urandom()));
			end
			for (p = 0; p < len; p++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					send_item(MODE_SAMPLE, 13'($urandom()), 16'($urandom()), 16'($urandom()));
				else if (r < 5)
					send_item(MODE_NONE, 13'($urandom()), 16'($urandom()), 16'($urandom()));
				send_item(MODE_READ, 13'($urandom()), 16'($urandom()), 16'($urandom()));
			end
			no_idle = 1'b0;
		end
	endtask

	// receiver
	initial begin
		int g;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				out_ready = 1'b0;
				repeat (hold_req) @(negedge clk);
				hold_req = 0;
			end else if (no_idle) begin
				out_ready = 1'b1;
			end else begin
				g = $urandom_range(0, 99);
				if (g < 2) begin
					out_ready = 1'b0;
					repeat ($urandom_range(10, 60)) @(negedge clk);
				end else begin
					out_ready = (g < 75);
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", out_item);
			end else begin
				exp_item = expected_q.pop_front();
				if (out_item.output_value !== exp_item.output_value ||
						out_item.saturated !== exp_item.saturated ||
						out_item.row_last !== exp_item.row_last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected val %h sat %b last %b, got %h %b %b",
							exp_item.output_value, exp_item.saturated, exp_item.row_last,
							out_item.output_value, out_item.saturated, out_item.row_last);
				end
			end
		end
	end

	initial begin
		int w;
		errors = 0;
		cycles = 0;
		hold_req = 0;
		no_idle = 1'b0;
		sent_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BLOCK_LOG2;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		m_block_log2 = 4'd8;
		m_row_blocks = 6'd1;
		m_signs_en = 1'b0;
		m_perm_en = 1'b0;
		m_rep = 14'd1;
		m_groups = 14'd1;
		m_head = 14'd1;
		m_loaded = 0;
		m_read = 0;
		m_row_len = 0;
		m_pending = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_reads();
		test_sign_fill();
		test_basic_rows();
		test_saturation();
		test_range_limits();
		test_resize_mid_row();
		test_backpressure();
		test_random();

		w = 0;
		while (expected_q.size() != 0 && w < 200000) begin
			@(negedge clk);
			w++;
		end
		repeat (100) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("PASS signed_block_hadamard_rotation_unit");
		else
			$display("FAIL signed_block_hadamard_rotation_unit");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/hbr_pkg.sv
rtl/hbr_ram.sv
rtl/hbr_front.sv
rtl/hbr_engine.sv
rtl/signed_block_hadamard_rotation_unit.sv
tb/signed_block_hadamard_rotation_unit_tb.sv
